>>> src/ptfg_pkg.sv
// Package for the periodic test frame generator.
// Holds sizes, op and register codes, and the item and table entry types.
// No dependencies.
package ptfg_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int MAX_FRAMES = 16;
   localparam int STAGGER = 7;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [4:0] ACTIVE_RESET = 5'd14;
   localparam logic [15:0] STEP_RESET = 16'd100;

   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD    = 2'd0;
   localparam op_type OP_RESTART = 2'd1;
   localparam op_type OP_TICK    = 2'd2;

   typedef logic csr_idx_type;
   localparam csr_idx_type CSR_ACTIVE = 1'b0;
   localparam csr_idx_type CSR_STEP   = 1'b1;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic [3:0]  slot;
      logic [10:0] frame_id;
      logic [3:0]  frame_len;
      logic [15:0] period_ms;
   } req_type;

   typedef struct packed {
      logic [10:0] out_id;
      logic [3:0]  out_len;
      logic [63:0] out_payload;
      logic [3:0]  out_slot;
      logic        resynced;
      logic [31:0] resync_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      csr_idx_type index;
      logic [15:0] wdata;
   } csr_type;

   typedef struct packed {
      logic [10:0] id;
      logic [3:0]  len;
      logic [15:0] period;
   } slot_cfg_type;

   typedef struct packed {
      logic [31:0] due;
      logic [7:0]  seq;
      logic        sent;
   } slot_run_type;

endpackage

>>> src/ptfg_if.sv
// Handshake channels of the periodic test frame generator.
// Depends on ptfg_pkg for the payload types.
interface ptfg_req_if;
   logic             valid;
   logic             ready;
   ptfg_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptfg_rsp_if;
   logic             valid;
   logic             ready;
   ptfg_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptfg_csr_if;
   logic             valid;
   logic             ready;
   ptfg_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/periodic_test_frame_generator.sv
// Periodic test frame generator, top level.
// Depends on ptfg_pkg and the channel interfaces in ptfg_if.
//
// Channels: req_ch takes items (load slot, restart run, time tick), rsp_ch
// gives one item per emitted frame, csr_ch writes active_slots (index 0)
// and signal_step_ms (index 1); csr_ch is always ready.
// Load and restart give no item. A tick runs a 32-step restoring
// divider for now_ms / signal_step_ms, then visits each active slot
// (table memory read, then evaluate and write back), then hands over
// the final frame.
// One frame is held back in a staging register so that the last flag is
// known; the output register holds the frame shown on rsp_ch. The next
// item is taken while the final frame still waits on rsp_ch.
// If the receiver stalls, the slot walk holds in its evaluate step.
// Reset restores active_slots 14, signal step 100 and an all-zero table;
// per-entry valid bits stand in for the zero contents, so no clearing pass.
module periodic_test_frame_generator (
   input logic clock,
   input logic reset,
   ptfg_req_if.sink req_ch,
   ptfg_rsp_if.source rsp_ch,
   ptfg_csr_if.sink csr_ch
);
   import ptfg_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] active_ff;
   logic [15:0] step_ff;
   logic [31:0] now_ff, now_in;
   logic [31:0] base_ff, base_in;
   logic stagger_ff, stagger_in;
   logic [31:0] resync_ff, resync_in;
   logic [SLOTS-1:0] cfg_vld_ff, cfg_vld_in;
   logic [SLOTS-1:0] run_vld_ff, run_vld_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   rsp_type pend_ff, pend_in, out_ff, out_in;
   logic pend_vld_ff, pend_vld_in, out_vld_ff, out_vld_in;

   slot_cfg_type cfg_mem [SLOTS];
   slot_run_type run_mem [SLOTS];
   slot_cfg_type cfg_rd_ff;
   slot_run_type run_rd_ff;

   logic req_take, rsp_take, out_free;
   logic [IDX_W-1:0] addr, load_addr;
   logic load_we, run_we;
   slot_cfg_type cfg_cur;
   slot_run_type run_cur, run_new;
   logic [15:0] step_eff;
   logic [16:0] rem_sh;
   logic div_ge;
   logic [3:0] len8;
   logic [31:0] per32, diff, due1, diff2;
   logic emit, rs, go;
   rsp_type frame;
   int unsigned lim_calc;

   function automatic logic [63:0] build_payload(input logic [3:0] len,
                                                 input logic [7:0] seq,
                                                 input logic [7:0] b1,
                                                 input logic [7:0] id8);
      logic [7:0] d [8];
      logic [7:0] sum;
      logic [63:0] p;
      int n;
      n = int'(len);
      sum = 8'd0;
      p = '0;
      for (int b = 0; b < 8; b++) begin
         d[b] = 8'd0;
         if (b == 0 && n >= 1) d[b] = seq;
         else if (b == 1 && n > 2) d[b] = b1;
         else if (b >= 2 && b + 1 < n) d[b] = id8 + 8'(b);
      end
      for (int b = 0; b < 8; b++) begin
         if (b + 1 < n) sum = sum + d[b];
      end
      for (int b = 0; b < 8; b++) begin
         if (n > 1 && b == n - 1) d[b] = ~sum;
         if (b < n) p[8*b +: 8] = d[b];
      end
      return p;
   endfunction

   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_take = rsp_ch.valid && rsp_ch.ready;
   assign out_free = !out_vld_ff || rsp_take;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.data = out_ff;

   assign addr = idx_ff[IDX_W-1:0];
   assign load_addr = IDX_W'(req_ch.data.slot);
   assign load_we = req_take && (req_ch.data.op == OP_LOAD)
                    && (32'(req_ch.data.slot) < 32'(SLOTS));

   // slot table entries read as zero, run entries as restart value, until written
   always_comb begin
      cfg_cur = cfg_vld_ff[addr] ? cfg_rd_ff : '0;
      if (run_vld_ff[addr]) begin
         run_cur = run_rd_ff;
      end else begin
         run_cur.due = stagger_ff ? base_ff + 32'(STAGGER) * 32'(idx_ff) : base_ff;
         run_cur.seq = 8'd0;
         run_cur.sent = 1'b0;
      end
   end

   always_comb begin
      step_eff = (step_ff == 16'd0) ? 16'd1 : step_ff;
      rem_sh = {rem_ff[15:0], quo_ff[31]};
      div_ge = rem_sh >= {1'b0, step_eff};
      len8 = (cfg_cur.len > 4'd8) ? 4'd8 : cfg_cur.len;
      per32 = {16'd0, cfg_cur.period};
      diff = now_ff - run_cur.due;
      due1 = run_cur.due + per32;
      diff2 = now_ff - due1;
      rs = (per32 != 32'd0) && !diff2[31] && (diff2 > per32);
      emit = (per32 == 32'd0) ? !run_cur.sent : !diff[31];
      run_new.due = (per32 == 32'd0) ? run_cur.due : (rs ? now_ff + per32 : due1);
      run_new.seq = run_cur.seq + 8'd1;
      run_new.sent = (per32 == 32'd0) ? 1'b1 : run_cur.sent;
      frame.out_id = cfg_cur.id;
      frame.out_len = len8;
      frame.out_payload = build_payload(len8, run_cur.seq,
                                        quo_ff[7:0] + 8'(idx_ff), cfg_cur.id[7:0]);
      frame.out_slot = 4'(idx_ff);
      frame.resynced = rs;
      frame.resync_total = resync_ff + 32'(rs);
      frame.last = 1'b0;
      go = !emit || !pend_vld_ff || out_free;
      lim_calc = 32'(active_ff);
      if (lim_calc > 32'(SLOTS)) lim_calc = 32'(SLOTS);
      if (lim_calc > 32'(MAX_FRAMES)) lim_calc = 32'(MAX_FRAMES);
   end

   always_comb begin
      state_in = state_ff;
      now_in = now_ff;
      base_in = base_ff;
      stagger_in = stagger_ff;
      resync_in = resync_ff;
      cfg_vld_in = cfg_vld_ff;
      run_vld_in = run_vld_ff;
      idx_in = idx_ff;
      lim_in = lim_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !rsp_take;
      run_we = 1'b0;
      if (load_we) cfg_vld_in[load_addr] = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_ch.data.op)
                  OP_RESTART: begin
                     base_in = req_ch.data.now_ms;
                     stagger_in = 1'b1;
                     resync_in = 32'd0;
                     run_vld_in = '0;
                  end
                  OP_TICK: begin
                     now_in = req_ch.data.now_ms;
                     quo_in = req_ch.data.now_ms;
                     rem_in = 17'd0;
                     cnt_in = '0;
                     idx_in = '0;
                     lim_in = CNT_W'(lim_calc);
                     state_in = ST_DIV;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? rem_sh - {1'b0, step_eff} : rem_sh;
            quo_in = {quo_ff[30:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = (lim_ff == '0) ? ST_FLUSH : ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (go) begin
               if (emit) begin
                  run_we = 1'b1;
                  run_vld_in[addr] = 1'b1;
                  resync_in = frame.resync_total;
                  if (pend_vld_ff) begin
                     out_in = pend_ff;
                     out_vld_in = 1'b1;
                  end
                  pend_in = frame;
                  pend_vld_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == lim_ff) ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in = pend_ff;
               out_in.last = 1'b1;
               out_vld_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         cfg_mem[load_addr] <= '{id: req_ch.data.frame_id, len: req_ch.data.frame_len,
                                 period: req_ch.data.period_ms};
      end
      if (state_ff == ST_READ) cfg_rd_ff <= cfg_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (run_we) run_mem[addr] <= run_new;
      if (state_ff == ST_READ) run_rd_ff <= run_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= ACTIVE_RESET;
         step_ff <= STEP_RESET;
         base_ff <= 32'd0;
         stagger_ff <= 1'b0;
         resync_ff <= 32'd0;
         cfg_vld_ff <= '0;
         run_vld_ff <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         stagger_ff <= stagger_in;
         resync_ff <= resync_in;
         cfg_vld_ff <= cfg_vld_in;
         run_vld_ff <= run_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.data.index)
               CSR_ACTIVE: active_ff <= csr_ch.data.wdata[4:0];
               CSR_STEP: step_ff <= csr_ch.data.wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      idx_ff <= idx_in;
      lim_ff <= lim_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.data.out_len <= 4'd8)
      else $error("frame length above eight");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> $past(state_ff) == ST_READ || $past(state_ff) == ST_EVAL)
      else $error("evaluate without table read");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.data))
      else $error("frame changed while stalled");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> state_ff != ST_IDLE)
      else $error("staged frame left at idle");

endmodule

>>> test/periodic_test_frame_generator_test.sv
// Testbench for the periodic test frame generator: slot loads, restarts and ticks
// driven with random gaps, frames checked against a behavioral schedule model.
// Depends on ptfg_pkg, ptfg_if and the generator top level.
`timescale 1ns / 100ps

module periodic_test_frame_generator_test;
   import ptfg_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptfg_req_if req_ch ();
   ptfg_rsp_if rsp_ch ();
   ptfg_csr_if csr_ch ();

   periodic_test_frame_generator i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   // schedule model state
   logic [31:0] sch_due [SLOTS];
   logic [7:0]  sch_seq [SLOTS];
   logic        sch_sent [SLOTS];
   logic [10:0] sch_id [SLOTS];
   logic [3:0]  sch_len [SLOTS];
   logic [15:0] sch_period [SLOTS];
   logic [31:0] sch_resyncs;
   logic [4:0]  cfg_active;
   logic [15:0] cfg_step;

   req_type pending_items[$];
   rsp_type expected_frames[$];
   int      errors = 0;
   int      frames_seen = 0;
   int      ticks_sent = 0;
   int      stall_long = 0;
   int      idle_cycles = 0;
   bit      done_sending = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] frame_payload(int idx, logic [31:0] now, int len,
                                                  logic [7:0] ctr);
      logic [7:0]  d [8];
      logic [7:0]  sum;
      logic [63:0] p;
      logic [31:0] step;
      p = '0;
      sum = '0;
      step = (cfg_step == 0) ? 32'd1 : {16'd0, cfg_step};
      for (int b = 0; b < 8; b++) d[b] = '0;
      if (len >= 1) d[0] = ctr;
      if (len > 2) d[1] = 8'(now / step + idx);
      for (int b = 2; b + 1 < len; b++) d[b] = 8'(sch_id[idx] + b);
      if (len > 1) begin
         for (int b = 0; b + 1 < len; b++) sum = sum + d[b];
         d[len - 1] = ~sum;
      end
      for (int b = 0; b < len; b++) p[8*b +: 8] = d[b];
      return p;
   endfunction

   function automatic void schedule_item(req_type it);
      int          n;
      int          len;
      int          first;
      logic [31:0] diff;
      logic        rs;
      rsp_type     f;
      first = expected_frames.size();
      case (it.op)
         OP_LOAD: begin
            sch_id[it.slot] = it.frame_id;
            sch_len[it.slot] = it.frame_len;
            sch_period[it.slot] = it.period_ms;
         end
         OP_RESTART: begin
            for (int i = 0; i < SLOTS; i++) begin
               sch_due[i] = it.now_ms + STAGGER * i;
               sch_seq[i] = '0;
               sch_sent[i] = 1'b0;
            end
            sch_resyncs = '0;
         end
         OP_TICK: begin
            n = (cfg_active > SLOTS) ? SLOTS : cfg_active;
            for (int i = 0; i < n; i++) begin
               rs = 1'b0;
               len = (sch_len[i] > 8) ? 8 : sch_len[i];
               if (sch_period[i] == 0) begin
                  if (sch_sent[i]) continue;
                  sch_sent[i] = 1'b1;
               end else begin
                  diff = it.now_ms - sch_due[i];
                  if (diff[31]) continue;
                  sch_due[i] = sch_due[i] + sch_period[i];
                  diff = it.now_ms - sch_due[i];
                  if (!diff[31] && diff > sch_period[i]) begin
                     sch_due[i] = it.now_ms + sch_period[i];
                     sch_resyncs = sch_resyncs + 1;
                     rs = 1'b1;
                  end
               end
               f.out_id = sch_id[i];
               f.out_len = 4'(len);
               f.out_payload = frame_payload(i, it.now_ms, len, sch_seq[i]);
               f.out_slot = 4'(i);
               f.resynced = rs;
               f.resync_total = sch_resyncs;
               f.last = 1'b0;
               sch_seq[i] = sch_seq[i] + 1;
               expected_frames.push_back(f);
            end
            if (expected_frames.size() > first)
               expected_frames[expected_frames.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // driver
   int req_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (req_ch.valid && !req_ch.ready) begin
      end else begin
         if (req_ch.valid) begin
            schedule_item(req_ch.data);
            if (req_ch.data.op == OP_TICK) ticks_sent++;
            req_wait = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) req_wait = 0;
         end
         if (req_wait > 0 || pending_items.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (req_wait > 0) req_wait--;
         end else begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_items.pop_front();
         end
      end
   end

   // monitor
   int      rsp_wait = 0;
   rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            frames_seen++;
            if (expected_frames.size() == 0) begin
               errors++;
               $display("%0t: unexpected frame %p", $time, rsp_ch.data);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_ch.data !== want) begin
                  errors++;
                  $display("%0t: frame mismatch expected %p actual %p", $time, want,
                           rsp_ch.data);
               end
            end
            rsp_wait = $urandom_range(0, 8);
            if ($urandom_range(0, 2) == 0) rsp_wait = 0;
         end
         if (stall_long > 0) begin
            stall_long--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_type make_item(op_type op, logic [31:0] now, int slot,
                                          int id, int len, int per);
      req_type it;
      it.op = op;
      it.now_ms = now;
      it.slot = 4'(slot);
      it.frame_id = 11'(id);
      it.frame_len = 4'(len);
      it.period_ms = 16'(per);
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_ch.valid || expected_frames.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [15:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= {idx, value};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_ACTIVE) cfg_active = value[4:0];
      else cfg_step = value;
   endtask

   task automatic random_phase(int count, logic [31:0] start);
      logic [31:0] now;
      int          r;
      now = start;
      pending_items.push_back(make_item(OP_RESTART, now, 0, 0, 0, 0));
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 19);
         if (r < 4)
            pending_items.push_back(make_item(OP_LOAD, $urandom, $urandom_range(0, 15),
               $urandom_range(0, 2047), $urandom_range(0, 15),
               ($urandom_range(0, 4) == 0) ? 0 :
               ($urandom_range(0, 5) == 0 ? $urandom_range(0, 65535)
                                          : $urandom_range(1, 40))));
         else if (r == 4)
            pending_items.push_back(make_item(OP_RESTART, now, 0, 0, 0, 0));
         else if (r == 5)
            pending_items.push_back(make_item(op_type'(3), $urandom, $urandom, $urandom,
                                              $urandom, $urandom));
         else begin
            now = now + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                     : $urandom_range(0, 12));
            pending_items.push_back(make_item(OP_TICK, now, $urandom, $urandom,
                                              $urandom, $urandom));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         sch_due[i] = '0; sch_seq[i] = '0; sch_sent[i] = 1'b0;
         sch_id[i] = '0; sch_len[i] = '0; sch_period[i] = '0;
      end
      sch_resyncs = '0;
      cfg_active = ACTIVE_RESET;
      cfg_step = STEP_RESET;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: tick before restart, extremes, long lengths, once-only slots
      pending_items.push_back(make_item(OP_TICK, 32'd5, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_LOAD, 0, 0, 2047, 8, 65535));
      pending_items.push_back(make_item(OP_LOAD, 0, 1, 0, 0, 0));
      pending_items.push_back(make_item(OP_LOAD, 0, 2, 1234, 15, 10));
      pending_items.push_back(make_item(OP_LOAD, 0, 3, 5, 1, 3));
      pending_items.push_back(make_item(OP_LOAD, 0, 15, 1023, 2, 1));
      pending_items.push_back(make_item(OP_LOAD, 0, 13, 77, 3, 5));
      pending_items.push_back(make_item(op_type'(3), 32'hffff_ffff, 15, 2047, 15, 65535));
      pending_items.push_back(make_item(OP_RESTART, 32'hffff_ffe0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 32'hffff_ffe0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 32'hffff_fff8, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 32'h0000_0040, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 32'h0001_0100, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 32'h0001_0101, 0, 0, 0, 0));
      wait_drained();

      write_csr(CSR_ACTIVE, 16'd16);
      write_csr(CSR_STEP, 16'd0);
      pending_items.push_back(make_item(OP_TICK, 32'hffff_ffff, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_TICK, 32'h0002_0000, 0, 0, 0, 0));
      wait_drained();

      // load every slot, then let the receiver stall while ticks pile up
      for (int s = 0; s < SLOTS; s++)
         pending_items.push_back(make_item(OP_LOAD, 0, s, $urandom_range(0, 2047),
                                           $urandom_range(0, 9), $urandom_range(1, 4)));
      pending_items.push_back(make_item(OP_RESTART, 32'd1000, 0, 0, 0, 0));
      wait_drained();
      stall_long = 400;
      for (int k = 0; k < 6; k++)
         pending_items.push_back(make_item(OP_TICK, 32'd1200 + 4 * k, 0, 0, 0, 0));
      wait_drained();

      write_csr(CSR_STEP, 16'hffff);
      write_csr(CSR_ACTIVE, 16'd0);
      random_phase(10, $urandom);
      wait_drained();
      write_csr(CSR_ACTIVE, 16'd31);
      write_csr(CSR_STEP, 16'd7);
      random_phase(40, $urandom);
      wait_drained();
      write_csr(CSR_ACTIVE, 16'd5);
      write_csr(CSR_STEP, 16'd1);
      random_phase(30, $urandom);
      wait_drained();
      write_csr(CSR_ACTIVE, 16'd14);
      write_csr(CSR_STEP, 16'd100);
      random_phase(40, 32'hffff_ff00);
      wait_drained();

      $display("Covered %0d ticks, %0d frames checked, several slot counts and steps.",
               ticks_sent, frames_seen);
      if (errors == 0 && expected_frames.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
